[design/rit_pkg.sv]
// Shared constants, types and the digit-to-ASCII function for the radix integer-to-text block.
package rit_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned FLAGS_W     = 2;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = STORE_AW + 1;
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam int unsigned FLAG_UNSIGNED = 0;
  localparam int unsigned FLAG_LOWER    = 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < 4'd10) begin
      return CHAR_ZERO + dx;
    end
    return (lower ? CHAR_LOWER : CHAR_UPPER) + dx - 7'd10;
  endfunction

endpackage

[design/rit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rit_div.sv]
// Iterative restoring divider: wide dividend by a small base, several quotient bits per cycle.
module rit_div #(
  parameter int unsigned DIV_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIV_W-1:0]              dividend_i,
  input  logic [rit_pkg::RADIX_W-1:0]   divisor_i,
  output logic [DIV_W-1:0]              quotient_o,
  output rit_pkg::div_rsp_t             rsp_o
);
  import rit_pkg::*;

  localparam int unsigned CHUNKS = DIV_W / STEP_BITS;
  localparam int unsigned LEFT_W = $clog2(CHUNKS + 1);

  logic                 busy_q, busy_d;
  logic [LEFT_W-1:0]    left_q, left_d;
  logic                 done_q, done_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   rem_next;

  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    r     = rem_q;
    qbits = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      t = {r, quo_q[DIV_W-1-k]};
      if (t >= divisor_i) begin
        t = t - divisor_i;
        qbits[STEP_BITS-1-k] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  always_comb begin
    busy_d = busy_q;
    left_d = left_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      left_d = LEFT_W'(CHUNKS);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d  = (quo_q << STEP_BITS) | DIV_W'(qbits);
      rem_d  = rem_next;
      left_d = left_q - 1'b1;
      if (left_q == LEFT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      left_q <= left_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;
  assign rsp_o      = '{done: done_q, rem: rem_q};

endmodule

[design/radix_integer_to_text.sv]
// Top level of the radix integer-to-text converter: sequencer, digit store and output register.
//
//   port group  dir  tdata fields (low bit up)                          tlast
//   s_axis      in   value[31:0] radix[36:32] format_flags[38:37] pad  -
//   m_axis      out  text_char[6:0] pad                                 last_char
//
// Each digit takes one pass of the shared divider, at most 32 digits; then
// one character per cycle, while the output is not stalled, leaves through the
// digit RAM read stage and the output register, '-' first for a negative value in signed mode.
// Reset clears the sequencer and the output valid; the digit RAM needs no clearing.
// A stalled output holds the word and the read stage; input is ready only when idle.
module radix_integer_to_text #(
  parameter int unsigned VALUE_BITS = rit_pkg::FIELD_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // value[31:0], radix[36:32], format_flags[38:37], zero [39]
  input  logic [rit_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // text_char[6:0], zero [7]
  output logic [rit_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import rit_pkg::*;

  localparam int unsigned MAG_W    = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam bit          HAS_SIGN = (VALUE_BITS <= FIELD_W);
  localparam int unsigned DIV_W    = ((MAG_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [DIV_W-1:0]    mag_q, mag_d;
  logic [RADIX_W-1:0]  base_q, base_d;
  logic                neg_q, neg_d;
  logic                lower_q, lower_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [STORE_AW-1:0] rd_idx_q, rd_idx_d;
  logic [COUNT_W-1:0]  rd_left_q, rd_left_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic [FIELD_W-1:0]  in_value;
  logic [RADIX_W-1:0]  in_radix;
  logic [FLAGS_W-1:0]  in_flags;
  logic [MAG_W-1:0]    vm;
  logic                in_neg;
  logic                accept;
  logic                out_free;
  logic                issue;
  logic                div_start;
  logic [DIV_W-1:0]    quotient;
  div_rsp_t            div_rsp;
  logic                ram_we;
  logic [DIGIT_W-1:0]  ram_rdata;

  assign in_value = s_axis_tdata_i[FIELD_W-1:0];
  assign in_radix = s_axis_tdata_i[FIELD_W+RADIX_W-1:FIELD_W];
  assign in_flags = s_axis_tdata_i[FIELD_W+RADIX_W+FLAGS_W-1:FIELD_W+RADIX_W];
  assign vm       = in_value[MAG_W-1:0];
  assign in_neg   = HAS_SIGN && !in_flags[FLAG_UNSIGNED] && vm[MAG_W-1];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign issue           = (state_q == S_EMIT) && (rd_left_q != '0) && (!pend_q || out_free);
  assign div_start       = (state_q == S_START);
  assign ram_we          = (state_q == S_DIV) && div_rsp.done;

  rit_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (base_q),
    .quotient_o (quotient),
    .rsp_o      (div_rsp)
  );

  rit_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[STORE_AW-1:0]),
    .wdata_i (div_rsp.rem),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    base_d      = base_q;
    neg_d       = neg_q;
    lower_d     = lower_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    rd_left_d   = rd_left_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_radix < RADIX_MIN) begin
            base_d = RADIX_MIN;
          end else if (in_radix > RADIX_MAX) begin
            base_d = RADIX_MAX;
          end else begin
            base_d = in_radix;
          end
          neg_d   = in_neg;
          lower_d = in_flags[FLAG_LOWER];
          mag_d   = DIV_W'(in_neg ? (MAG_W'(0) - vm) : vm);
          cnt_d   = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mag_d = quotient;
          cnt_d = cnt_q + 1'b1;
          if ((quotient == '0) || (cnt_q == COUNT_W'(STORE_DEPTH - 1))) begin
            rd_idx_d  = cnt_q[STORE_AW-1:0];
            rd_left_d = cnt_q + 1'b1;
            state_d   = neg_q ? S_SIGN : S_EMIT;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pend_q && out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(ram_rdata, lower_q);
          out_last_d  = pend_last_q;
          pend_d      = 1'b0;
        end
        if (issue) begin
          pend_d      = 1'b1;
          pend_last_d = (rd_left_q == COUNT_W'(1));
          rd_idx_d    = rd_idx_q - 1'b1;
          rd_left_d   = rd_left_q - 1'b1;
        end
        if ((rd_left_q == '0) && (!pend_q || out_free)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    base_q      <= base_d;
    neg_q       <= neg_d;
    lower_q     <= lower_d;
    rd_idx_q    <= rd_idx_d;
    pend_last_q <= pend_last_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_char_q);
  assign m_axis_tlast_o  = out_last_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done outside the divide state");

  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_EMIT))
    else $error("digit read pending outside the emit state");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rd_left_q == '0) && !pend_q)
    else $error("idle with digits left to send");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_W'(STORE_DEPTH))
    else $error("digit count beyond store depth");

endmodule
